FILE: sv/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// Used by pps_ctrl, pps_dp and the top level; depends on nothing.
`default_nettype none
package pps_pkg;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;
  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_IDLESCAN,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic pick;
    logic idle_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic all_done;
    logic found;
  } stat_t;
endpackage
`default_nettype wire

FILE: sv/pps_ctrl.sv
// Controller state machine of the scheduler: sequences a round over the table.
// Depends on pps_pkg.
`default_nettype none
module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  in_cmd,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output cmd_t       cmd,
  input  wire stat_t stat
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_next = stat.all_done ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        state_next = stat.found ? ST_FINISH : ST_IDLESCAN;
      end
      ST_IDLESCAN: begin
        cmd.idle_step = 1'b1;
        if (stat.scan_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/pps_dp.sv
// Datapath of the scheduler: process table, flags, time and result registers.
// Depends on pps_pkg; driven by pps_ctrl.
`default_nettype none
module pps_dp
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [3:0]  slot,
  input  wire logic [15:0] proc_id,
  input  wire logic [15:0] arrival_time,
  input  wire logic [11:0] burst_len,
  input  wire logic [7:0]  prio,
  input  wire logic [11:0] io_len,
  output logic             ran,
  output logic [3:0]       run_slot,
  output logic [15:0]      run_id,
  output logic [15:0]      slice_start,
  output logic [15:0]      slice_end,
  output logic [11:0]      left_after,
  output logic             finished,
  output logic             all_done,
  output logic [15:0]      now_time
);
  localparam int NP = (MAX_PROCS < 16) ? MAX_PROCS : 16;
  localparam int IW = (NP > 1) ? $clog2(NP) : 1;

  logic [15:0] id_table   [NP];
  logic [15:0] ready_time [NP];
  logic [11:0] remaining  [NP];
  logic [7:0]  prio_table [NP];
  logic [11:0] io_left    [NP];
  logic [NP-1:0] done_flags, in_io_flags, loaded;
  logic [15:0] clock_now;
  logic [IW-1:0] idx;
  logic found;
  logic [IW-1:0] win;
  logic [7:0] win_prio;
  logic pend, io_any;
  logic [15:0] earliest_arr;

  logic [15:0] time_inc;
  logic [11:0] io_dec;
  logic io_zero, ready_i;
  logic [15:0] rt_i;
  logic [11:0] rem_dec;
  logic all_done_now;
  logic [15:0] clock_fin;

  assign time_inc = (clock_now == TIME_MAX) ? TIME_MAX : clock_now + 16'd1;
  assign all_done_now = ((done_flags | ~loaded) == '1);
  assign stat.all_done = all_done_now;
  assign stat.scan_last = (idx == IW'(NP - 1));
  assign stat.found = found;

  // Countdown and readiness of the entry under the scan pointer.
  always_comb begin
    io_dec = (io_left[idx] != 12'd0) ? io_left[idx] - 12'd1 : 12'd0;
    io_zero = in_io_flags[idx] && (io_dec == 12'd0);
    rt_i = io_zero ? clock_now : ready_time[idx];
    ready_i = loaded[idx] && !done_flags[idx] && (!in_io_flags[idx] || io_zero)
              && (rt_i <= clock_now);
    rem_dec = remaining[win] - 12'd1;
  end

  // Time at the end of the round; only an idle round moves it here.
  always_comb begin
    clock_fin = clock_now;
    if (!found && !all_done_now) begin
      if (pend) begin
        clock_fin = (earliest_arr > clock_now) ? earliest_arr : time_inc;
      end else if (io_any) begin
        clock_fin = time_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_flags <= '0;
      in_io_flags <= '0;
      loaded <= '0;
      clock_now <= '0;
      idx <= '0;
    end else begin
      if (cmd.load && (32'(slot) < NP)) begin
        id_table[slot[IW-1:0]] <= proc_id;
        ready_time[slot[IW-1:0]] <= arrival_time;
        remaining[slot[IW-1:0]] <= burst_len;
        prio_table[slot[IW-1:0]] <= prio;
        io_left[slot[IW-1:0]] <= io_len;
        done_flags[slot[IW-1:0]] <= 1'b0;
        in_io_flags[slot[IW-1:0]] <= 1'b0;
        for (int k = 0; k < NP; k++) begin
          if (k <= 32'(slot)) loaded[k] <= 1'b1;
        end
      end
      if (cmd.scan_start) begin
        idx <= '0;
        found <= 1'b0;
        pend <= 1'b0;
        io_any <= 1'b0;
        ran <= 1'b0;
        run_slot <= '0;
        run_id <= '0;
        slice_start <= '0;
        slice_end <= '0;
        left_after <= '0;
        finished <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (loaded[idx] && in_io_flags[idx]) begin
          io_left[idx] <= io_dec;
          if (io_zero) begin
            in_io_flags[idx] <= 1'b0;
            ready_time[idx] <= clock_now;
          end
        end
        if (ready_i) begin
          if (remaining[idx] == 12'd0) begin
            done_flags[idx] <= 1'b1;
          end else if (!found || prio_table[idx] < win_prio) begin
            found <= 1'b1;
            win <= idx;
            win_prio <= prio_table[idx];
          end
        end
        idx <= stat.scan_last ? '0 : idx + IW'(1);
      end
      if (cmd.pick && found) begin
        remaining[win] <= rem_dec;
        if (rem_dec == 12'd0) begin
          done_flags[win] <= 1'b1;
        end else if (io_left[win] != 12'd0) begin
          in_io_flags[win] <= 1'b1;
        end
        clock_now <= time_inc;
        ran <= 1'b1;
        run_slot <= 4'(win);
        run_id <= id_table[win];
        slice_start <= clock_now;
        slice_end <= time_inc;
        left_after <= rem_dec;
        finished <= (rem_dec == 12'd0);
      end
      if (cmd.idle_step) begin
        if (loaded[idx] && !done_flags[idx]) begin
          if (in_io_flags[idx]) begin
            io_any <= 1'b1;
          end else if (!pend || ready_time[idx] < earliest_arr) begin
            pend <= 1'b1;
            earliest_arr <= ready_time[idx];
          end
        end
        idx <= stat.scan_last ? '0 : idx + IW'(1);
      end
      if (cmd.finish) begin
        clock_now <= clock_fin;
        all_done <= all_done_now;
        now_time <= clock_fin;
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler; instantiates pps_ctrl and
// pps_dp and depends on pps_pkg.
`default_nettype none
// A load request (cmd 0) writes one process table entry and gives no
// result. A step request (cmd 1) runs one scheduling round: the
// datapath walks the table one entry per cycle to advance I/O countdowns,
// retire empty processes and pick the lowest priority value (lowest slot on
// ties), then charges the winner one time unit. When nothing is ready a
// second walk finds the earliest pending arrival. A round with everything
// done skips both walks. The result is held in registers until taken, and
// the block accepts the next request only after that. Table entries have no
// reset and must be loaded in slot order starting from slot 0.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [3:0]  slot,
  input  wire logic [15:0] proc_id,
  input  wire logic [15:0] arrival_time,
  input  wire logic [11:0] burst_len,
  input  wire logic [7:0]  prio,
  input  wire logic [11:0] io_len,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             ran,
  output logic [3:0]       run_slot,
  output logic [15:0]      run_id,
  output logic [15:0]      slice_start,
  output logic [15:0]      slice_end,
  output logic [11:0]      left_after,
  output logic             finished,
  output logic             all_done,
  output logic [15:0]      now_time
);
  cmd_t  dp_cmd;
  stat_t dp_stat;

  pps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_cmd(cmd),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(dp_cmd), .stat(dp_stat)
  );

  pps_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk(clk), .rst(rst), .cmd(dp_cmd), .stat(dp_stat),
    .slot(slot), .proc_id(proc_id), .arrival_time(arrival_time),
    .burst_len(burst_len), .prio(prio), .io_len(io_len),
    .ran(ran), .run_slot(run_slot), .run_id(run_id),
    .slice_start(slice_start), .slice_end(slice_end),
    .left_after(left_after), .finished(finished),
    .all_done(all_done), .now_time(now_time)
  );

  // No new request is taken while a result is waiting.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  // A run result always spans exactly one unit or saturates.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && ran) |-> (slice_end == slice_start + 16'd1 ||
                            slice_end == TIME_MAX)) else $error("bad slice");
  // A finished slice leaves no units behind.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> (left_after == 12'd0)) else $error("finished with units left");
endmodule
`default_nettype wire

FILE: dv/preemptive_priority_scheduler_test.sv
// Self-checking testbench for the preemptive priority scheduler top level.
// Depends on pps_pkg and preemptive_priority_scheduler; needs nothing else.
module preemptive_priority_scheduler_test;
  import pps_pkg::*;

  localparam int NPROC = 16;
  localparam int RANDOM_ITEMS = 750;

  // One expected scheduling round, laid out like the result ports.
  typedef struct packed {
    logic        ran;
    logic [3:0]  run_slot;
    logic [15:0] run_id;
    logic [15:0] slice_start;
    logic [15:0] slice_end;
    logic [11:0] left_after;
    logic        finished;
    logic        all_done;
    logic [15:0] now_time;
  } round_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_LOAD;
  logic [3:0] slot = '0;
  logic [15:0] proc_id = '0;
  logic [15:0] arrival_time = '0;
  logic [11:0] burst_len = '0;
  logic [7:0] prio = '0;
  logic [11:0] io_len = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ran;
  logic [3:0] run_slot;
  logic [15:0] run_id;
  logic [15:0] slice_start;
  logic [15:0] slice_end;
  logic [11:0] left_after;
  logic finished;
  logic all_done;
  logic [15:0] now_time;

  preemptive_priority_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .slot(slot), .proc_id(proc_id), .arrival_time(arrival_time),
    .burst_len(burst_len), .prio(prio), .io_len(io_len),
    .out_valid(out_valid), .out_stall(out_stall),
    .ran(ran), .run_slot(run_slot), .run_id(run_id),
    .slice_start(slice_start), .slice_end(slice_end),
    .left_after(left_after), .finished(finished),
    .all_done(all_done), .now_time(now_time)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the process table, updated as requests are accepted.
  logic [15:0] tbl_id [NPROC];
  logic [15:0] tbl_ready [NPROC];
  logic [11:0] tbl_left [NPROC];
  logic [7:0]  tbl_prio [NPROC];
  logic [11:0] tbl_io [NPROC];
  logic        tbl_done [NPROC];
  logic        tbl_in_io [NPROC];
  logic [15:0] sched_clock = '0;
  int          table_used = 0;

  round_t expected_rounds[$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 1;
  int hold_cycles = 0;

  function automatic logic [15:0] tick(input logic [15:0] t);
    return (t == TIME_MAX) ? t : t + 16'd1;
  endfunction

  function automatic logic table_finished();
    for (int i = 0; i < table_used; i++) begin
      if (!tbl_done[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Runs one scheduling round on the shadow table and returns its outcome.
  function automatic round_t schedule_round();
    round_t r;
    logic found;
    logic pend;
    logic io_any;
    int win;
    logic [15:0] next_arrival;
    r = '0;
    found = 1'b0;
    win = 0;
    if (!table_finished()) begin
      // I/O countdowns first; a finished countdown makes the process ready now.
      for (int i = 0; i < table_used; i++) begin
        if (tbl_in_io[i]) begin
          if (tbl_io[i] != 0) tbl_io[i]--;
          if (tbl_io[i] == 0) begin
            tbl_in_io[i] = 1'b0;
            tbl_ready[i] = sched_clock;
          end
        end
      end
      // Retire empty ready processes and pick the best ready one.
      for (int i = 0; i < table_used; i++) begin
        if (tbl_done[i] || tbl_in_io[i] || tbl_ready[i] > sched_clock) continue;
        if (tbl_left[i] == 0) begin
          tbl_done[i] = 1'b1;
          continue;
        end
        if (!found || tbl_prio[i] < tbl_prio[win]) begin
          found = 1'b1;
          win = i;
        end
      end
      if (found) begin
        r.ran = 1'b1;
        r.run_slot = win[3:0];
        r.run_id = tbl_id[win];
        r.slice_start = sched_clock;
        r.slice_end = tick(sched_clock);
        tbl_left[win]--;
        if (tbl_left[win] == 0) tbl_done[win] = 1'b1;
        if (tbl_io[win] != 0 && !tbl_done[win]) tbl_in_io[win] = 1'b1;
        sched_clock = r.slice_end;
        r.left_after = tbl_left[win];
        r.finished = tbl_done[win];
      end else begin
        // Idle: jump to the earliest arrival, or creep forward by one.
        pend = 1'b0;
        io_any = 1'b0;
        next_arrival = '0;
        for (int i = 0; i < table_used; i++) begin
          if (tbl_done[i]) continue;
          if (tbl_in_io[i]) begin
            io_any = 1'b1;
            continue;
          end
          if (!pend || tbl_ready[i] < next_arrival) begin
            pend = 1'b1;
            next_arrival = tbl_ready[i];
          end
        end
        if (pend)
          sched_clock = (next_arrival > sched_clock) ? next_arrival : tick(sched_clock);
        else if (io_any)
          sched_clock = tick(sched_clock);
      end
    end
    r.all_done = table_finished();
    r.now_time = sched_clock;
    return r;
  endfunction

  // Offers one request and waits until the block takes it. The sender works
  // in bursts; valid only drops for a gap, so it is never lowered and raised
  // in the same step.
  task automatic send_request(input logic c, input logic [3:0] s, input logic [15:0] id,
                              input logic [15:0] arr, input logic [11:0] bl,
                              input logic [7:0] pr, input logic [11:0] io);
    in_valid <= 1'b1;
    cmd <= c;
    slot <= s;
    proc_id <= id;
    arrival_time <= arr;
    burst_len <= bl;
    prio <= pr;
    io_len <= io;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (c == CMD_STEP) begin
      expected_rounds.push_back(schedule_round());
    end else begin
      tbl_id[s] = id;
      tbl_ready[s] = arr;
      tbl_left[s] = bl;
      tbl_prio[s] = pr;
      tbl_io[s] = io;
      tbl_done[s] = 1'b0;
      tbl_in_io[s] = 1'b0;
      if (s + 1 > table_used) table_used = s + 1;
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  task automatic load_entry(input int s, input logic [15:0] id, input logic [15:0] arr,
                            input logic [11:0] bl, input logic [7:0] pr,
                            input logic [11:0] io);
    send_request(CMD_LOAD, s[3:0], id, arr, bl, pr, io);
  endtask

  // Steps carry don't-care payload, so random junk rides along on them.
  task automatic step_round();
    send_request(CMD_STEP, 4'($urandom), 16'($urandom), 16'($urandom),
                 12'($urandom), 8'($urandom), 12'($urandom));
  endtask

  task automatic step_until_done(input int limit);
    for (int k = 0; k < limit && !table_finished(); k++) step_round();
    step_round();
  endtask

  // With nothing loaded a round changes nothing and reports all done.
  task automatic test_empty_table();
    step_round();
    step_round();
  endtask

  // Priority order, ties to the lower slot, a zero-length process and the
  // field extremes.
  task automatic test_priorities();
    load_entry(0, 16'hFFFF, 16'd0, 12'd2, 8'd5, 12'd0);
    load_entry(1, 16'h0000, 16'd0, 12'd1, 8'd5, 12'd0);
    load_entry(2, 16'h1234, 16'd1, 12'd2, 8'd0, 12'd0);
    load_entry(3, 16'hA5A5, 16'd0, 12'd0, 8'd255, 12'd0);
    load_entry(4, 16'h5A5A, 16'd3, 12'd1, 8'd255, 12'd0);
    step_until_done(20);
  endtask

  // An I/O phase, and a stretch where only a process in I/O is left.
  task automatic test_io_phase();
    load_entry(0, 16'h0101, sched_clock, 12'd3, 8'd1, 12'd4);
    load_entry(1, 16'h0202, sched_clock, 12'd1, 8'd9, 12'd0);
    step_until_done(20);
  endtask

  // An arrival in the future makes the idle round jump time forward, and
  // reloading a slot that is in I/O clears its I/O flag.
  task automatic test_idle_jump();
    load_entry(0, 16'h0303, sched_clock + 16'd40, 12'd1, 8'd3, 12'd2);
    load_entry(1, 16'h0404, sched_clock + 16'd7, 12'd2, 8'd4, 12'd4095);
    step_round();
    step_round();
    load_entry(1, 16'h0505, sched_clock, 12'd1, 8'd2, 12'd0);
    step_until_done(20);
  endtask

  // The block holds one result; a long receiver hold-off makes it stall its
  // input while the sender keeps offering requests.
  task automatic test_backpressure();
    for (int s = 0; s < 4; s++)
      load_entry(s, 16'($urandom), sched_clock, 12'($urandom_range(1, 4)),
                 8'($urandom_range(0, 3)), 12'($urandom_range(0, 3)));
    hold_cycles = 300;
    burst_left = 1000;
    for (int k = 0; k < 20; k++) step_round();
  endtask

  // Random scenarios: refill the table up to a random size, then run rounds.
  task automatic test_random_mix();
    int n;
    int loads;
    while (items_sent < RANDOM_ITEMS - 120) begin
      n = $urandom_range(1, NPROC);
      if (n < table_used) n = table_used;
      loads = 0;
      for (int s = 0; s < n; s++) begin
        if (s >= table_used || !tbl_done[s] || $urandom_range(0, 3) == 0) begin
          load_entry(s, 16'($urandom),
                     16'((sched_clock > 16'd65500) ? sched_clock
                         : sched_clock + 16'($urandom_range(0, 12))),
                     ($urandom_range(0, 15) == 0) ? 12'($urandom)
                                                  : 12'($urandom_range(0, 5)),
                     ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, 3)),
                     ($urandom_range(0, 15) == 0) ? 12'($urandom)
                     : (($urandom_range(0, 1) == 0) ? 12'd0
                                                    : 12'($urandom_range(1, 4))));
          loads++;
        end
      end
      step_until_done(3 * loads + 4);
    end
  endtask

  // Time saturates at its maximum instead of wrapping.
  task automatic test_time_limit();
    for (int s = 0; s < table_used; s++)
      load_entry(s, 16'(s), 16'hFFFD, 12'd2, 8'(s), 12'(s % 2));
    step_until_done(60);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_priorities();
    test_io_phase();
    test_idle_jump();
    test_backpressure();
    test_random_mix();
    test_time_limit();
    in_valid <= 1'b0;
    while (expected_rounds.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("preemptive_priority_scheduler_test: done, clean");
    end else begin
      $display("preemptive_priority_scheduler_test: done, errors");
    end
    $finish;
  end

  // Receiver: a forced hold-off when asked for, otherwise a stall rate picked
  // anew for each stretch of random length, including stretches with no stalls.
  int stall_pct = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      if (mode_left == 0) begin
        mode_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: begin
            stall_pct = 0;
          end
          1: begin
            stall_pct = 30;
          end
          2: begin
            stall_pct = 70;
          end
          default: begin
            stall_pct = 95;
          end
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compares every taken result with the oldest expected round.
  always @(posedge clk) begin
    round_t got;
    round_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{ran, run_slot, run_id, slice_start, slice_end, left_after,
              finished, all_done, now_time};
      if (expected_rounds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_rounds.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("preemptive_priority_scheduler_test: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
sv/pps_pkg.sv
sv/pps_ctrl.sv
sv/pps_dp.sv
sv/preemptive_priority_scheduler.sv
dv/preemptive_priority_scheduler_test.sv
